FILE: rtl/core/kwf_pkg.sv
`timescale 1ns / 1ps

package kwf_pkg;

   localparam int SLOT_W = 4;
   localparam int POS_W  = 4;
   localparam int BYTE_W = 8;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BYTE  = 2'd1,
      OP_EOL   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // One word as it travels down the cell chain
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              hit;
   } item_type;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/kwf_cell.sv
`timescale 1ns / 1ps

module kwf_cell #(
   parameter int CELL_INDEX      = 0,
   parameter int MAX_KEYWORD_LEN = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  kwf_pkg::item_type item_i,
   output kwf_pkg::item_type item_o
);
   import kwf_pkg::*;

   localparam int PW = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
   localparam int LW = $clog2(MAX_KEYWORD_LEN + 1);

   logic [BYTE_W-1:0]          chars_ff [MAX_KEYWORD_LEN];
   logic [LW-1:0]              len_ff, len_in;
   logic [MAX_KEYWORD_LEN-1:0] vec_ff, vec_in;
   logic                       hit_ff, hit_in;
   item_type                   item_ff, item_in;

   logic                       load_here;
   logic [PW-1:0]              pos_idx;
   logic [MAX_KEYWORD_LEN-1:0] eq;
   logic [MAX_KEYWORD_LEN-1:0] shifted;
   logic [MAX_KEYWORD_LEN-1:0] vec_next;
   logic [PW-1:0]              tail_idx;

   assign load_here = item_i.valid && (item_i.op == OP_LOAD)
                      && (32'(item_i.slot) == 32'(CELL_INDEX))
                      && (32'(item_i.pos) < 32'(MAX_KEYWORD_LEN));
   assign pos_idx   = PW'(item_i.pos);
   assign tail_idx  = PW'(len_ff - LW'(1));
   assign shifted   = MAX_KEYWORD_LEN'({vec_ff, 1'b1});

   always_comb begin
      for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
         eq[j] = (chars_ff[j] == item_i.data) && (32'(j) < 32'(len_ff));
      end
      vec_next = shifted & eq;
   end

   always_comb begin
      len_in  = len_ff;
      vec_in  = vec_ff;
      hit_in  = hit_ff;
      item_in = item_i;
      if (item_i.valid) begin
         case (item_i.op)
            OP_LOAD: begin
               if (load_here && item_i.last) begin
                  len_in = LW'(5'(item_i.pos) + 5'd1);
               end
            end
            OP_BYTE: begin
               if (len_ff != '0) begin
                  vec_in = vec_next;
                  if (vec_next[tail_idx]) begin
                     hit_in = 1'b1;
                  end
               end
            end
            OP_EOL: begin
               // merge this keyword's line hit into the passing word, restart line
               item_in.hit = item_i.hit | hit_ff;
               hit_in      = 1'b0;
               vec_in      = '0;
            end
            OP_CLEAR: begin
               len_in = '0;
               vec_in = '0;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         vec_ff        <= '0;
         hit_ff        <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         len_ff        <= len_in;
         vec_ff        <= vec_in;
         hit_ff        <= hit_in;
         item_ff       <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (load_here) begin
            chars_ff[pos_idx] <= item_i.data;
         end
      end
   end

   assign item_o = item_ff;

endmodule

FILE: rtl/core/keyword_line_filter.sv
`timescale 1ns / 1ps

// Case-insensitive keyword line filter. Words enter on req_ at up to one per
// cycle and pass down a chain of NUM_KEYWORDS cells, one keyword per cell; each
// cell applies the word to its own keyword (load a character, advance its
// partial-match vector, close the line, clear) and hands it to the next cell.
// An end-of-line word leaves the chain carrying the OR of all cells' line hits
// and is registered once more before it appears on rsp_; other words
// give no result. Sustained rate is one word per cycle, set by the cell chain
// stepping in lockstep; a stalled result stalls the whole chain.
module keyword_line_filter #(
   parameter int NUM_KEYWORDS    = 16,
   parameter int MAX_KEYWORD_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // op[1:0], pattern_slot[5:2], char_pos[9:6],
                                    // data_byte[17:10], zero fill[23:18]
   input  logic        req_tlast,   // pattern_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // is_negative[0], zero fill[7:1]
);
   import kwf_pkg::*;

   item_type chain [NUM_KEYWORDS+1];
   item_type head;
   logic     advance;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_hit_ff, rsp_hit_in;
   item_type tail;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      head.valid = req_tvalid;
      head.op    = op_type'(req_tdata[1:0]);
      head.slot  = req_tdata[5:2];
      head.pos   = req_tdata[9:6];
      head.data  = fold_case(req_tdata[17:10]);
      head.last  = req_tlast;
      head.hit   = 1'b0;
   end

   assign chain[0] = head;

   for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_cell
      kwf_cell #(
         .CELL_INDEX     (k),
         .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .item_i (chain[k]),
         .item_o (chain[k+1])
      );
   end

   assign tail = chain[NUM_KEYWORDS];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (advance) begin
         rsp_valid_in = tail.valid && (tail.op == OP_EOL);
         rsp_hit_in   = tail.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_hit_ff};

   // a held result freezes the chain, so no new word may enter
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("chain advanced under a stalled result");

   // an end-of-line word leaving the chain must become a result
   assert property (@(posedge clock) disable iff (reset)
      advance && tail.valid && tail.op == OP_EOL |=> rsp_tvalid)
      else $error("end-of-line word lost at chain exit");

   // other words never produce a result
   assert property (@(posedge clock) disable iff (reset)
      advance && !(tail.valid && tail.op == OP_EOL) |=> !rsp_tvalid)
      else $error("result without end-of-line word");

endmodule

FILE: bench/keyword_line_filter_tb.sv
`timescale 1ns / 1ps

module keyword_line_filter_tb;
   import kwf_pkg::*;

   localparam int NUM_KEYWORDS    = 16;
   localparam int MAX_KEYWORD_LEN = 16;
   localparam int TOTAL_WORDS     = 1320;
   localparam int QUIET_AFTER     = 1170;
   localparam int DRAIN_CYCLES    = 4 * (NUM_KEYWORDS + 1) + 20;
   localparam int CYCLE_LIMIT     = 400000;

   // Keeps its own copy of the keyword table and the per-keyword shift-and
   // vectors, and queues the hit flag that each end-of-line word must return.
   class line_match_scoreboard;
      logic [7:0]  kw_char [NUM_KEYWORDS][MAX_KEYWORD_LEN];
      int          kw_len [NUM_KEYWORDS];
      logic [MAX_KEYWORD_LEN-1:0] match_vec [NUM_KEYWORDS];
      logic        line_hit;
      logic        hit_flags_q [$];
      int          errors;

      function new();
         for (int k = 0; k < NUM_KEYWORDS; k++) begin
            kw_len[k]    = 0;
            match_vec[k] = '0;
         end
         line_hit = 1'b0;
         errors   = 0;
      endfunction

      function logic [7:0] fold_byte(logic [7:0] b);
         return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
      endfunction

      task report(string msg);
         errors++;
         $display("check failed at %0t: %s", $time, msg);
      endtask

      function int pending();
         return hit_flags_q.size();
      endfunction

      function void note_word(op_type op, logic [3:0] slot, logic [3:0] pos,
                              logic [7:0] data, logic last);
         logic [7:0] c;
         logic [MAX_KEYWORD_LEN-1:0] eq;
         c = fold_byte(data);
         case (op)
            OP_LOAD: begin
               kw_char[slot][pos] = c;
               if (last) kw_len[slot] = pos + 1;
            end
            OP_BYTE: begin
               for (int k = 0; k < NUM_KEYWORDS; k++) begin
                  if (kw_len[k] != 0) begin
                     eq = '0;
                     for (int i = 0; i < kw_len[k]; i++)
                        if (kw_char[k][i] == c) eq[i] = 1'b1;
                     match_vec[k] = {match_vec[k][MAX_KEYWORD_LEN-2:0], 1'b1} & eq;
                     if (match_vec[k][kw_len[k]-1]) line_hit = 1'b1;
                  end
               end
            end
            OP_EOL: begin
               hit_flags_q.push_back(line_hit);
               line_hit = 1'b0;
               for (int k = 0; k < NUM_KEYWORDS; k++) match_vec[k] = '0;
            end
            default: begin
               // clear keeps the line hit already found
               for (int k = 0; k < NUM_KEYWORDS; k++) begin
                  kw_len[k]    = 0;
                  match_vec[k] = '0;
               end
            end
         endcase
      endfunction

      task check_word(logic got);
         logic want;
         if (hit_flags_q.size() == 0) begin
            report($sformatf("result %b with no end of line pending", got));
         end else begin
            want = hit_flags_q.pop_front();
            if (got !== want)
               report($sformatf("is_negative got %b, want %b", got, want));
         end
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;

   line_match_scoreboard sb = new();

   // what the stimulus side has loaded, used to embed keywords in lines and
   // to keep a keyword length from covering a never-written character
   logic [7:0]  sent_text [NUM_KEYWORDS][MAX_KEYWORD_LEN];
   logic [15:0] sent_written [NUM_KEYWORDS];
   int          sent_len [NUM_KEYWORDS];
   int          words_sent = 0;
   bit          allow_idle = 1'b0;
   int          stall_left = 0;
   int unsigned cycles     = 0;

   keyword_line_filter #(
      .NUM_KEYWORDS    (NUM_KEYWORDS),
      .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_word(input op_type op, input logic [3:0] slot,
                            input logic [3:0] pos, input logic [7:0] data,
                            input logic last);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, data, pos, slot, op};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(op, slot, pos, data, last);
      words_sent++;
      if (op == OP_LOAD) begin
         sent_text[slot][pos]    = data;
         sent_written[slot][pos] = 1'b1;
         if (last) sent_len[slot] = pos + 1;
      end else if (op == OP_CLEAR) begin
         for (int k = 0; k < NUM_KEYWORDS; k++) sent_len[k] = 0;
      end
   endtask

   // mostly letters a-d in either case so that keywords hit often
   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      c = 8'h61 + 8'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) c = c & 8'hDF;
      return c;
   endfunction

   task automatic load_keyword(input logic [3:0] slot, input int len);
      for (int p = 0; p < len; p++)
         send_word(OP_LOAD, slot, 4'(p), pick_char(), p == len - 1);
   endtask

   task automatic send_line_byte(input logic [7:0] c);
      send_word(OP_BYTE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), c,
                1'($urandom_range(0, 1)));
   endtask

   task automatic send_line();
      int k;
      logic [7:0] c;
      repeat ($urandom_range(0, 10)) send_line_byte(pick_char());
      k = $urandom_range(0, NUM_KEYWORDS - 1);
      if (sent_len[k] != 0 && $urandom_range(0, 1)) begin
         // embed a stored keyword with its letters in random case
         for (int i = 0; i < sent_len[k]; i++) begin
            c = sent_text[k][i];
            if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A)
               c = $urandom_range(0, 1) ? (c | 8'h20) : (c & 8'hDF);
            send_line_byte(c);
         end
      end
      repeat ($urandom_range(0, 6)) send_line_byte(pick_char());
      send_word(OP_EOL, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_noise();
      logic [3:0]  slot;
      logic [3:0]  pos;
      logic [15:0] need;
      logic        last;
      slot = 4'($urandom_range(0, 15));
      pos  = 4'($urandom_range(0, 15));
      need = 16'hFFFF >> (15 - pos);
      last = $urandom_range(0, 1) &&
             (((sent_written[slot] | (16'd1 << pos)) & need) == need);
      case ($urandom_range(0, 3))
         0:       send_word(OP_LOAD, slot, pos, 8'($urandom_range(0, 255)), last);
         1:       send_word(OP_BYTE, slot, pos, 8'($urandom_range(0, 255)), last);
         2:       send_word(OP_EOL, slot, pos, 8'($urandom_range(0, 255)), last);
         default: send_word(OP_CLEAR, slot, pos, 8'($urandom_range(0, 255)), last);
      endcase
   endtask

   // result side: take words, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata[0]);
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         if (stall_left == 0) rsp_tready <= 1'b1;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 10);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         sb.report($sformatf("timeout, %0d results outstanding", sb.pending()));
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         sent_written[k] = '0;
         sent_len[k]     = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty dictionary never matches
      send_word(OP_BYTE, 4'd0, 4'd0, "A", 1'b0);
      send_word(OP_EOL, 4'd0, 4'd0, 8'h00, 1'b0);
      // mixed-case keyword against a line in the opposite case
      send_word(OP_LOAD, 4'd0, 4'd0, "A", 1'b0);
      send_word(OP_LOAD, 4'd0, 4'd1, "z", 1'b1);
      send_word(OP_BYTE, 4'd0, 4'd0, "a", 1'b0);
      send_word(OP_BYTE, 4'd0, 4'd0, "Z", 1'b0);
      send_word(OP_EOL, 4'd0, 4'd0, 8'h00, 1'b0);
      // top slot and top position, no length given
      send_word(OP_LOAD, 4'd15, 4'd15, 8'hFF, 1'b0);
      // NUL is an ordinary keyword byte; a clear mid-line keeps the hit
      send_word(OP_LOAD, 4'd1, 4'd0, 8'h00, 1'b1);
      send_word(OP_BYTE, 4'd0, 4'd0, 8'h00, 1'b0);
      send_word(OP_CLEAR, 4'd0, 4'd0, 8'h00, 1'b0);
      send_word(OP_EOL, 4'd0, 4'd0, 8'h00, 1'b0);
      send_word(OP_BYTE, 4'd0, 4'd0, 8'h00, 1'b0);
      send_word(OP_EOL, 4'd0, 4'd0, 8'h00, 1'b0);
      // rewriting a character keeps the old length in force
      send_word(OP_LOAD, 4'd2, 4'd0, "x", 1'b0);
      send_word(OP_LOAD, 4'd2, 4'd1, "y", 1'b1);
      send_word(OP_LOAD, 4'd2, 4'd0, "[", 1'b0);
      send_word(OP_BYTE, 4'd0, 4'd0, "@", 1'b0);
      send_word(OP_BYTE, 4'd0, 4'd0, "[", 1'b0);
      send_word(OP_BYTE, 4'd0, 4'd0, "Y", 1'b0);
      send_word(OP_EOL, 4'd0, 4'd0, 8'h00, 1'b0);

      while (words_sent < TOTAL_WORDS) begin
         allow_idle = (words_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0)
            send_word(OP_CLEAR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 4))
            load_keyword(4'($urandom_range(0, 15)), ($urandom_range(0, 9) == 0) ?
                         $urandom_range(5, MAX_KEYWORD_LEN) : $urandom_range(1, 4));
         repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 6) == 0) send_noise();
            send_line();
         end
      end
      allow_idle = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/kwf_pkg.sv
rtl/core/kwf_cell.sv
rtl/core/keyword_line_filter.sv
bench/keyword_line_filter_tb.sv
